>>> rtl/rbna_pkg.sv
// ============================================================================
// rbna_pkg
// Shared types and constants for the ring buffer nonzero average block.
// ============================================================================
`default_nettype none

package rbna_pkg;

    // Field widths of the request and result items
    localparam int RAW_W = 16;
    localparam int WIN_W = 8;
    localparam int AVG_W = 24;
    localparam int FRAC_W = 8;

    // Request type codes
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Status of the serial divider as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/ring_buffer_nonzero_average.sv
// ============================================================================
// ring_buffer_nonzero_average
// Ring of byte-swapped power readings with a query for the mean of the
// nonzero entries among the most recent ones (8 fractional bits, truncated).
// ============================================================================
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   in       in_valid / in_stall  req_type, raw_reading, window_count
//   out      out_valid/out_stall  average, average_valid
//
// A store request is written to the RAM when it is accepted. A query reads
// window_count entries from the RAM (one read per cycle on its single read
// port), takes the last read in the drain state and checks the count, then
// runs the bit-serial divider over 16 + clog2(DEPTH+1) + 8 quotient bits (one
// per cycle, then its done strobe), then loads the result register.
// An illegal window or one with no nonzero entry skips the walk or divider.
// Reset clears the per-entry valid bits at once; no clearing pass is needed.
// in_stall is high whenever a query is in progress; a stalled result holds
// the block in its final state only until the result register frees up.
//
`default_nettype none

module ring_buffer_nonzero_average
    import rbna_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             req_type,
    input  wire logic [RAW_W-1:0] raw_reading,
    input  wire logic [WIN_W-1:0] window_count,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [AVG_W-1:0] average,
    output logic                  average_valid
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = RAW_W + CNT_W;
    localparam int DVD_W = SUM_W + FRAC_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [WIN_W:0]   DEPTH_LIM = (WIN_W + 1)'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_CHECK,
        S_DIV,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  wi_reg, wi_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [WIN_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEPTH-1:0]  vld_reg, vld_next;
    logic              pend_reg, pend_next;
    logic              vbit_reg, vbit_next;
    logic              zero_reg, zero_next;
    logic              out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic              avg_vld_reg, avg_vld_next;

    logic              in_acc;
    logic              store_acc;
    logic              win_ok;
    logic [IDX_W-1:0]  rd_addr;
    logic [RAW_W-1:0]  rdata;
    logic              acc_hit;
    logic              out_free;
    logic              div_start;
    div_stat_t         div_stat;
    logic [DVD_W-1:0]  quotient;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign store_acc = in_acc && (req_type == REQ_STORE);
    assign win_ok    = (window_count != '0) && ({1'b0, window_count} <= DEPTH_LIM);

    // Walk backward from the newest entry, wrapping below zero
    assign rd_addr = (ptr_reg == '0) ? LAST_IDX : ptr_reg - 1'b1;

    // Count an entry only if it was written and holds a nonzero reading
    assign acc_hit = pend_reg && vbit_reg && (rdata != '0);

    assign out_free  = !out_valid_reg || !out_stall;
    assign div_start = (state_reg == S_CHECK) && (cnt_reg != '0);

    rbna_ram #(
        .WIDTH (RAW_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_acc),
        .waddr (wi_reg),
        .wdata ({raw_reading[7:0], raw_reading[15:8]}),
        .re    (state_reg == S_WALK),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    rbna_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_reg, {FRAC_W{1'b0}}}),
        .divisor  (cnt_reg),
        .status   (div_stat),
        .quotient (quotient)
    );

    // Sequencer next-state and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        wi_next        = wi_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        vld_next       = vld_reg;
        pend_next      = (state_reg == S_WALK);
        vbit_next      = vld_reg[rd_addr];
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && out_stall;
        avg_next       = avg_reg;
        avg_vld_next   = avg_vld_reg;

        // Accumulate the entry read in the previous cycle
        if (acc_hit)
        begin
            sum_next = sum_reg + SUM_W'(rdata);
            cnt_next = cnt_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (store_acc)
                begin
                    vld_next[wi_reg] = 1'b1;
                    wi_next = (wi_reg == LAST_IDX) ? '0 : wi_reg + 1'b1;
                end
                else if (in_acc)
                begin
                    if (win_ok)
                    begin
                        ptr_next   = wi_reg;
                        rem_next   = window_count;
                        sum_next   = '0;
                        cnt_next   = '0;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        zero_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            S_WALK:
            begin
                ptr_next = rd_addr;
                rem_next = rem_reg - 1'b1;
                if (rem_reg == WIN_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (cnt_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = zero_reg ? '0 : quotient[AVG_W-1:0];
                    avg_vld_next   = !zero_reg;
                    zero_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the registered out_valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wi_reg        <= '0;
            vld_reg       <= '0;
            pend_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wi_reg        <= wi_next;
            vld_reg       <= vld_next;
            pend_reg      <= pend_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        rem_reg     <= rem_next;
        sum_reg     <= sum_next;
        cnt_reg     <= cnt_next;
        vbit_reg    <= vbit_next;
        avg_reg     <= avg_next;
        avg_vld_reg <= avg_vld_next;
    end

    assign out_valid     = out_valid_reg;
    assign average       = avg_reg;
    assign average_valid = avg_vld_reg;

    // An invalid result always carries a zero average
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !average_valid |-> average == '0)
        else $error("invalid result with nonzero average");

    // The divider runs only while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == S_DIV)
        else $error("divider busy outside divide state");

    // An illegal window goes straight to the result stage
    a_bad_window: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && req_type == REQ_QUERY && !win_ok |=> state_reg == S_EMIT && zero_reg)
        else $error("illegal window did not bypass the walk");

    // The nonzero count never passes the ring depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> cnt_reg <= CNT_W'(DEPTH))
        else $error("nonzero count exceeds depth");

endmodule

`default_nettype wire

>>> rtl/rbna_ram.sv
// ============================================================================
// rbna_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module rbna_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/rbna_div.sv
// ============================================================================
// rbna_div
// Bit-serial restoring divider: one quotient bit per cycle, shifted into the
// dividend register as the dividend bits shift out.
// ============================================================================
`default_nettype none

module rbna_div
    import rbna_pkg::*;
#(
    parameter int DVD_W = 31,
    parameter int DVS_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_stat_t             status,
    output logic      [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    trial;
    logic [DVS_W+1:0]  diff;
    logic              fits;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits  = ~diff[DVS_W+1];

    // Control: load on start, count down one step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dvd_reg;

endmodule

`default_nettype wire
